// File: rtl/core/gpr_pkg.sv
// ----------------------------------------------------------------------------
// gpr_pkg
// Shared widths, reset values and codes for the gamepad report builder.
// ----------------------------------------------------------------------------
package gpr_pkg;

    localparam int AXIS_W   = 16;   // raw stick sample
    localparam int OUT_W    = 8;    // scaled report axis
    localparam int DZ_W     = 15;   // dead zone register
    localparam int CHG_W    = 16;   // change threshold register
    localparam int KEY_W    = 8;
    localparam int BTN_W    = 16;
    localparam int CFG_AW   = 2;
    localparam int CFG_DW   = 16;

    localparam logic [KEY_W-1:0] KEY_NONE   = 8'hFF;
    localparam logic [KEY_W-1:0] KEY_COUNT  = 8'd14;
    localparam int               AXIS_MAX   = 127;
    localparam int               SCALE_SH   = 15;   // divide by 32768

    localparam logic [DZ_W-1:0]  DEADZONE_RST = 15'd2000;
    localparam logic [CHG_W-1:0] CHANGE_RST   = 16'd500;

    localparam int BIT_LEFT_PRESS  = 14;
    localparam int BIT_RIGHT_PRESS = 15;

    // config register indexes
    localparam logic [CFG_AW-1:0] CFG_DEADZONE = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_CHANGE   = 2'd1;

    // send outcome codes
    localparam logic [1:0] SEND_OK   = 2'd0;
    localparam logic [1:0] SEND_BUSY = 2'd1;

endpackage

// File: rtl/core/gpr_axis.sv
// ----------------------------------------------------------------------------
// gpr_axis
// One stick axis: dead zone, change test against the committed sample,
// and scaling to the report range.
// ----------------------------------------------------------------------------
module gpr_axis import gpr_pkg::*; (
    input  logic signed [AXIS_W-1:0] raw,
    input  logic signed [AXIS_W-1:0] prev,
    input  logic        [DZ_W-1:0]   deadzone,
    input  logic        [CHG_W-1:0]  change_limit,
    output logic                     moved,
    output logic signed [OUT_W-1:0]  scaled
);

    function automatic logic signed [AXIS_W-1:0] dz_apply(
        input logic signed [AXIS_W-1:0] v,
        input logic        [DZ_W-1:0]   lim
    );
        logic signed [AXIS_W:0] vx;
        logic signed [AXIS_W:0] lx;
        vx = {v[AXIS_W-1], v};
        lx = signed'({{(AXIS_W+1-DZ_W){1'b0}}, lim});
        if (vx > -lx && vx < lx) begin
            return '0;
        end
        return v;
    endfunction

    localparam int PROD_W = AXIS_W + 8;

    logic signed [AXIS_W-1:0] dz_now;
    logic signed [AXIS_W-1:0] dz_prev;
    logic signed [AXIS_W:0]   diff;
    logic        [AXIS_W:0]   mag;
    logic signed [PROD_W-1:0] ext;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] biased;
    logic signed [PROD_W-SCALE_SH-1:0] quo;
    logic signed [PROD_W-SCALE_SH-1:0] qmax;

    assign dz_now  = dz_apply(raw, deadzone);
    assign dz_prev = dz_apply(prev, deadzone);

    assign diff  = {dz_now[AXIS_W-1], dz_now} - {dz_prev[AXIS_W-1], dz_prev};
    assign mag   = diff[AXIS_W] ? (AXIS_W+1)'(-diff) : diff;
    assign moved = mag > {1'b0, change_limit};

    // v * 127, then divide by 32768 truncating toward zero
    assign ext    = {{(PROD_W-AXIS_W){dz_now[AXIS_W-1]}}, dz_now};
    assign prod   = (ext <<< 7) - ext;
    assign biased = prod[PROD_W-1] ? prod + PROD_W'((1 << SCALE_SH) - 1) : prod;
    assign quo    = biased[PROD_W-1:SCALE_SH];
    assign qmax   = (PROD_W-SCALE_SH)'(AXIS_MAX);

    always_comb begin
        if (quo > qmax) begin
            scaled = OUT_W'(qmax);
        end else if (quo < -qmax) begin
            scaled = OUT_W'(-qmax);
        end else begin
            scaled = quo[OUT_W-1:0];
        end
    end

endmodule

// File: rtl/core/gamepad_report_builder.sv
// ----------------------------------------------------------------------------
// gamepad_report_builder
// Builds a gamepad report from each scan item when keys, buttons or axes
// changed or a retry is pending, and tracks the committed last sample.
// ----------------------------------------------------------------------------
//  channel   dir   handshake            payload
//  s_*       in    s_valid / s_ready    key, four axes, two buttons, link, send status
//  m_*       out   m_valid / m_ready    button bits, four scaled axes
//  cfg_*     in    cfg_we               cfg_addr, cfg_wdata
//
// One item per cycle unless a stalled result holds it: an item is decided
// and scaled in the input register, and an item that makes a report is
// registered into the result register as it leaves. Committed-sample state
// updates as the item leaves the input register, so the following item sees
// it. A stalled result holds the input register only when that item also makes a report.
// Reset is synchronous; there is no clearing pass.
// ----------------------------------------------------------------------------
module gamepad_report_builder import gpr_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,

    input  logic                     cfg_we,
    input  logic [CFG_AW-1:0]        cfg_addr,
    input  logic [CFG_DW-1:0]        cfg_wdata,

    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [KEY_W-1:0]         s_key_index,
    input  logic signed [AXIS_W-1:0] s_left_x_raw,
    input  logic signed [AXIS_W-1:0] s_left_y_raw,
    input  logic                     s_left_press,
    input  logic signed [AXIS_W-1:0] s_right_x_raw,
    input  logic signed [AXIS_W-1:0] s_right_y_raw,
    input  logic                     s_right_press,
    input  logic                     s_link_ready,
    input  logic [1:0]               s_send_status,

    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [BTN_W-1:0]         m_button_bits,
    output logic signed [OUT_W-1:0]  m_left_x_out,
    output logic signed [OUT_W-1:0]  m_left_y_out,
    output logic signed [OUT_W-1:0]  m_right_x_out,
    output logic signed [OUT_W-1:0]  m_right_y_out
);

    // config
    logic [DZ_W-1:0]  deadzone_reg;
    logic [CHG_W-1:0] change_reg;

    // input register
    logic                     in_valid_reg;
    logic [KEY_W-1:0]         key_reg;
    logic signed [AXIS_W-1:0] lx_reg, ly_reg, rx_reg, ry_reg;
    logic                     lp_reg, rp_reg, link_reg;
    logic [1:0]               status_reg;

    // committed sample
    logic [KEY_W-1:0]         prev_key_reg;
    logic signed [AXIS_W-1:0] prev_lx_reg, prev_ly_reg, prev_rx_reg, prev_ry_reg;
    logic                     prev_lp_reg, prev_rp_reg;
    logic                     pending_reg;

    // result register
    logic                     out_valid_reg;
    logic [BTN_W-1:0]         btn_reg;
    logic signed [OUT_W-1:0]  olx_reg, oly_reg, orx_reg, ory_reg;

    logic                     mv_lx, mv_ly, mv_rx, mv_ry;
    logic signed [OUT_W-1:0]  sc_lx, sc_ly, sc_rx, sc_ry;
    logic                     emit;
    logic                     out_free;
    logic                     fire;
    logic [BTN_W-1:0]         btn_next;

    gpr_axis u_lx (.raw(lx_reg), .prev(prev_lx_reg), .deadzone(deadzone_reg),
                   .change_limit(change_reg), .moved(mv_lx), .scaled(sc_lx));
    gpr_axis u_ly (.raw(ly_reg), .prev(prev_ly_reg), .deadzone(deadzone_reg),
                   .change_limit(change_reg), .moved(mv_ly), .scaled(sc_ly));
    gpr_axis u_rx (.raw(rx_reg), .prev(prev_rx_reg), .deadzone(deadzone_reg),
                   .change_limit(change_reg), .moved(mv_rx), .scaled(sc_rx));
    gpr_axis u_ry (.raw(ry_reg), .prev(prev_ry_reg), .deadzone(deadzone_reg),
                   .change_limit(change_reg), .moved(mv_ry), .scaled(sc_ry));

    assign emit = pending_reg || key_reg != prev_key_reg || lp_reg != prev_lp_reg
               || rp_reg != prev_rp_reg || mv_lx || mv_ly || mv_rx || mv_ry;

    assign out_free = !out_valid_reg || m_ready;
    // an item with no report retires even while the output is stalled
    assign fire     = in_valid_reg && (!emit || out_free);
    assign s_ready  = !in_valid_reg || fire;

    always_comb begin
        btn_next = '0;
        if (key_reg < KEY_COUNT) begin
            btn_next[key_reg[3:0]] = 1'b1;
        end
        btn_next[BIT_LEFT_PRESS]  = lp_reg;
        btn_next[BIT_RIGHT_PRESS] = rp_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            deadzone_reg <= DEADZONE_RST;
            change_reg   <= CHANGE_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_DEADZONE: deadzone_reg <= cfg_wdata[DZ_W-1:0];
                CFG_CHANGE:   change_reg   <= cfg_wdata[CHG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            key_reg    <= s_key_index;
            lx_reg     <= s_left_x_raw;
            ly_reg     <= s_left_y_raw;
            lp_reg     <= s_left_press;
            rx_reg     <= s_right_x_raw;
            ry_reg     <= s_right_y_raw;
            rp_reg     <= s_right_press;
            link_reg   <= s_link_ready;
            status_reg <= s_send_status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_key_reg <= KEY_NONE;
            prev_lx_reg  <= '0;
            prev_ly_reg  <= '0;
            prev_lp_reg  <= 1'b0;
            prev_rx_reg  <= '0;
            prev_ry_reg  <= '0;
            prev_rp_reg  <= 1'b0;
            pending_reg  <= 1'b0;
        end else if (fire && emit && link_reg) begin
            case (status_reg)
                SEND_OK: begin
                    pending_reg  <= 1'b0;
                    prev_key_reg <= key_reg;
                    prev_lx_reg  <= lx_reg;
                    prev_ly_reg  <= ly_reg;
                    prev_lp_reg  <= lp_reg;
                    prev_rx_reg  <= rx_reg;
                    prev_ry_reg  <= ry_reg;
                    prev_rp_reg  <= rp_reg;
                end
                SEND_BUSY: pending_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= fire && emit;
        end
        if (fire && emit) begin
            btn_reg <= btn_next;
            olx_reg <= sc_lx;
            oly_reg <= sc_ly;
            orx_reg <= sc_rx;
            ory_reg <= sc_ry;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_button_bits = btn_reg;
    assign m_left_x_out  = olx_reg;
    assign m_left_y_out  = oly_reg;
    assign m_right_x_out = orx_reg;
    assign m_right_y_out = ory_reg;

endmodule
